[rtl/mckw_pkg.sv]
package mckw_pkg;

    // Table geometry and field widths.
    localparam int ENTRIES    = 16;
    localparam int COUNT_BITS = 32;
    localparam int IDX_BITS   = $clog2(ENTRIES);
    localparam int ISSUE_BITS = $clog2(ENTRIES + 1);
    localparam int KEY_BITS   = 16;
    localparam int TIME_BITS  = 32;
    localparam int TMO_BITS   = 16;
    localparam int STAT_BITS  = 4;
    localparam int FUNC_BITS  = 2;

    // Configuration port.
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 16;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TIMEOUT   = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TERMINATE = 1'b1;
    localparam logic [TMO_BITS-1:0]     TIMEOUT_RESET = 16'd10;
    localparam logic                    TERM_RESET    = 1'b1;

    // Request functions.
    localparam logic [FUNC_BITS-1:0] FUNC_START = 2'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_STOP  = 2'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_KICK  = 2'd2;
    localparam logic [FUNC_BITS-1:0] FUNC_CHECK = 2'd3;

    // Result status codes.
    localparam logic [STAT_BITS-1:0] ST_OK        = 4'd0;
    localparam logic [STAT_BITS-1:0] ST_PRESENT   = 4'd1;
    localparam logic [STAT_BITS-1:0] ST_FULL      = 4'd2;
    localparam logic [STAT_BITS-1:0] ST_NOTFOUND  = 4'd3;
    localparam logic [STAT_BITS-1:0] ST_KICKED    = 4'd4;
    localparam logic [STAT_BITS-1:0] ST_WAITING   = 4'd5;
    localparam logic [STAT_BITS-1:0] ST_CLOCKJUMP = 4'd6;
    localparam logic [STAT_BITS-1:0] ST_TERMINATE = 4'd7;
    localparam logic [STAT_BITS-1:0] ST_FIRSTREP  = 4'd8;
    localparam logic [STAT_BITS-1:0] ST_REPORTED  = 4'd9;
    localparam logic [STAT_BITS-1:0] ST_EMPTY     = 4'd10;
    localparam logic [STAT_BITS-1:0] ST_HALTED    = 4'd11;

    // One incoming request.
    typedef struct packed {
        logic [FUNC_BITS-1:0] func;
        logic [KEY_BITS-1:0]  client_key;
        logic [TIME_BITS-1:0] now_seconds;
    } t_req;

    // One result.
    typedef struct packed {
        logic [STAT_BITS-1:0]        status;
        logic [KEY_BITS-1:0]         entry_key;
        logic signed [TIME_BITS-1:0] idle_seconds;
        logic                        last;
    } t_res;

    // One row of the entry table memory.
    typedef struct packed {
        logic [KEY_BITS-1:0]   key;
        logic [COUNT_BITS-1:0] kick_count;
        logic [COUNT_BITS-1:0] seen_count;
        logic [TIME_BITS-1:0]  alive_time;
        logic                  hang_reported;
    } t_row;

    localparam int ROW_BITS = $bits(t_row);

    // Access to the table memory.
    typedef struct packed {
        logic                re;
        logic                we;
        logic [IDX_BITS-1:0] addr;
        t_row                wdata;
    } t_ram_req;

endpackage

[rtl/multi_channel_kick_watchdog_top.sv]
// Watchdog table for up to ENTRIES clients. Start, stop and kick requests
// look their key up by reading the entry memory one row per cycle, then
// act on the table and load their one result into the output register.
// A check request walks the table, skipping free slots and reading,
// evaluating and writing back each valid entry: one result per valid entry,
// until a hang halts the block in terminate mode. An empty check, like any
// request to a halted block, gives one result without reading the table.
// A result waits while the output is stalled. The next request is taken as
// soon as the last result of the current one is in the output register,
// even while that result waits. Once halted by a hang in terminate mode,
// every request gets one halted result until reset.
module multi_channel_kick_watchdog_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  mckw_pkg::t_req                      i_req,
    output logic                                o_valid,
    input  logic                                i_stall,
    output mckw_pkg::t_res                      o_res,
    input  logic                                i_cfg_we,
    input  logic [mckw_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [mckw_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

    mckw_pkg::t_ram_req ram_req;
    mckw_pkg::t_row     ram_rdata;
    logic               out_free;
    logic               push;
    mckw_pkg::t_res     res;

    // Sequencer and entry evaluation.
    mckw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_valid),
        .o_req_stall (o_stall),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_ram       (ram_req),
        .i_ram_rdata (ram_rdata),
        .i_out_free  (out_free),
        .o_push      (push),
        .o_res       (res)
    );

    // Entry table memory.
    mckw_ram #(
        .WIDTH (mckw_pkg::ROW_BITS),
        .DEPTH (mckw_pkg::ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_re    (ram_req.re),
        .i_we    (ram_req.we),
        .i_addr  (ram_req.addr),
        .i_wdata (ram_req.wdata),
        .o_rdata (ram_rdata)
    );

    // Result output register.
    mckw_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res   (res),
        .o_free  (out_free),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (o_res)
    );

    // A result is only loaded into a free output register.
    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> out_free)
        else $error("result loaded into an occupied output register");

    // An accepted request keeps the block busy in the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("request accepted without leaving idle");

    // The single-port memory never sees a read and a write together.
    a_ram_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_req.re && ram_req.we))
        else $error("entry memory read and write in the same cycle");

endmodule

[rtl/mckw_ram.sv]
module mckw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_re,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single port: write, or registered read that holds when not enabled.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/mckw_out_reg.sv]
module mckw_out_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mckw_pkg::t_res i_res,
    output logic          o_free,
    output logic          o_valid,
    input  logic          i_stall,
    output mckw_pkg::t_res o_res
);

    logic           r_valid;
    mckw_pkg::t_res r_res;

    // The slot can take a new result when empty or when it drains this cycle.
    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

[rtl/mckw_ctrl.sv]
module mckw_ctrl (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_req_valid,
    output logic                                o_req_stall,
    input  mckw_pkg::t_req                      i_req,
    input  logic                                i_cfg_we,
    input  logic [mckw_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [mckw_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    output mckw_pkg::t_ram_req                  o_ram,
    input  mckw_pkg::t_row                      i_ram_rdata,
    input  logic                                i_out_free,
    output logic                                o_push,
    output mckw_pkg::t_res                      o_res
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_FIN  = 3'd2;
    localparam logic [2:0] S_CRD  = 3'd3;
    localparam logic [2:0] S_CEV  = 3'd4;

    localparam int E  = mckw_pkg::ENTRIES;
    localparam int IB = mckw_pkg::IDX_BITS;

    logic [2:0]                          r_state, n_state;
    mckw_pkg::t_req                      r_req, n_req;
    logic [E-1:0]                        r_valid, n_valid;
    logic                                r_halted, n_halted;
    logic [mckw_pkg::TMO_BITS-1:0]       r_timeout;
    logic                                r_term;
    logic [IB-1:0]                       r_idx, n_idx;
    logic [mckw_pkg::ISSUE_BITS-1:0]     r_issue, n_issue;
    logic                                r_pv, n_pv;
    logic [IB-1:0]                       r_pidx, n_pidx;
    logic                                r_found, n_found;
    logic [IB-1:0]                       r_slot, n_slot;
    mckw_pkg::t_row                      r_row, n_row;

    logic                                accept;
    logic                                free_found;
    logic [IB-1:0]                       free_slot;
    logic                                later;
    logic [mckw_pkg::TIME_BITS-1:0]      idle;
    logic [mckw_pkg::TIME_BITS-1:0]      limit;
    logic [mckw_pkg::TIME_BITS-1:0]      limit2;
    logic                                stale;
    logic                                over;
    logic                                jump;
    mckw_pkg::t_row                      row_upd;
    logic [mckw_pkg::STAT_BITS-1:0]      chk_status;
    logic                                chk_stop;

    assign accept      = i_req_valid && (r_state == S_IDLE);
    assign o_req_stall = (r_state != S_IDLE);

    // Lowest free slot of the table, from the valid bits.
    always_comb begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int j = E - 1; j >= 0; j--) begin
            if (!r_valid[j]) begin
                free_found = 1'b1;
                free_slot  = IB'(j);
            end
        end
    end

    // Is there a valid entry after the one being checked?
    always_comb begin
        later = 1'b0;
        for (int j = 0; j < E; j++) begin
            if (r_valid[j] && (j > int'(r_idx))) begin
                later = 1'b1;
            end
        end
    end

    // Evaluation of one entry during a check.
    always_comb begin
        idle    = r_req.now_seconds - i_ram_rdata.alive_time;
        limit   = mckw_pkg::TIME_BITS'(r_timeout);
        limit2  = mckw_pkg::TIME_BITS'({r_timeout, 1'b0});
        stale   = (i_ram_rdata.kick_count == i_ram_rdata.seen_count);
        jump    = idle[mckw_pkg::TIME_BITS-1] || (idle > limit2);
        over    = (idle > limit);
        row_upd = i_ram_rdata;
        chk_stop = 1'b0;
        if (!stale) begin
            row_upd.alive_time    = r_req.now_seconds;
            row_upd.seen_count    = i_ram_rdata.kick_count;
            row_upd.hang_reported = 1'b0;
            chk_status            = mckw_pkg::ST_KICKED;
        end else if (jump) begin
            row_upd.alive_time = r_req.now_seconds;
            chk_status         = mckw_pkg::ST_CLOCKJUMP;
        end else if (over) begin
            if (r_term) begin
                chk_status = mckw_pkg::ST_TERMINATE;
                chk_stop   = 1'b1;
            end else if (!i_ram_rdata.hang_reported) begin
                row_upd.hang_reported = 1'b1;
                chk_status            = mckw_pkg::ST_FIRSTREP;
            end else begin
                chk_status = mckw_pkg::ST_REPORTED;
            end
        end else begin
            chk_status = mckw_pkg::ST_WAITING;
        end
    end

    // Sequencer: table scan for start, stop and kick; entry walk for check.
    always_comb begin
        n_state  = r_state;
        n_req    = r_req;
        n_valid  = r_valid;
        n_halted = r_halted;
        n_idx    = r_idx;
        n_issue  = r_issue;
        n_pv     = r_pv;
        n_pidx   = r_pidx;
        n_found  = r_found;
        n_slot   = r_slot;
        n_row    = r_row;
        o_ram    = '0;
        o_ram.addr = r_idx;
        o_push   = 1'b0;
        o_res    = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_req = i_req;
                    if (r_halted) begin
                        n_state = S_FIN;
                    end else if (i_req.func == mckw_pkg::FUNC_CHECK) begin
                        n_idx   = '0;
                        n_state = (r_valid == '0) ? S_FIN : S_CRD;
                    end else begin
                        n_issue = '0;
                        n_pv    = 1'b0;
                        n_found = 1'b0;
                        n_state = S_SCAN;
                    end
                end
            end

            // One table read issued per cycle; compare as data returns.
            S_SCAN: begin
                if (r_issue < mckw_pkg::ISSUE_BITS'(E)) begin
                    o_ram.re   = 1'b1;
                    o_ram.addr = r_issue[IB-1:0];
                    n_issue    = r_issue + 1'b1;
                    n_pv       = 1'b1;
                    n_pidx     = r_issue[IB-1:0];
                end else begin
                    n_pv = 1'b0;
                end
                if (r_pv) begin
                    if (r_valid[r_pidx] && (i_ram_rdata.key == r_req.client_key)) begin
                        n_found = 1'b1;
                        n_slot  = r_pidx;
                        n_row   = i_ram_rdata;
                    end
                    if (r_pidx == IB'(E - 1)) begin
                        n_state = S_FIN;
                    end
                end
            end

            // Single-result requests: act on the table and report.
            S_FIN: begin
                if (i_out_free) begin
                    o_push          = 1'b1;
                    o_res.entry_key = r_req.client_key;
                    o_res.last      = 1'b1;
                    n_state         = S_IDLE;
                    if (r_halted) begin
                        o_res.status = mckw_pkg::ST_HALTED;
                    end else begin
                        case (r_req.func)
                            mckw_pkg::FUNC_START: begin
                                if (r_found) begin
                                    o_res.status = mckw_pkg::ST_PRESENT;
                                end else if (free_found) begin
                                    o_res.status                = mckw_pkg::ST_OK;
                                    o_ram.we                    = 1'b1;
                                    o_ram.addr                  = free_slot;
                                    o_ram.wdata.key             = r_req.client_key;
                                    o_ram.wdata.kick_count      = '0;
                                    o_ram.wdata.seen_count      = '0;
                                    o_ram.wdata.alive_time      = r_req.now_seconds;
                                    o_ram.wdata.hang_reported   = 1'b0;
                                    n_valid[free_slot]          = 1'b1;
                                end else begin
                                    o_res.status = mckw_pkg::ST_FULL;
                                end
                            end
                            mckw_pkg::FUNC_STOP: begin
                                if (r_found) begin
                                    o_res.status    = mckw_pkg::ST_OK;
                                    n_valid[r_slot] = 1'b0;
                                end else begin
                                    o_res.status = mckw_pkg::ST_NOTFOUND;
                                end
                            end
                            mckw_pkg::FUNC_KICK: begin
                                if (r_found) begin
                                    o_res.status           = mckw_pkg::ST_OK;
                                    o_ram.we               = 1'b1;
                                    o_ram.addr             = r_slot;
                                    o_ram.wdata            = r_row;
                                    o_ram.wdata.kick_count = r_row.kick_count + 1'b1;
                                end else begin
                                    o_res.status = mckw_pkg::ST_NOTFOUND;
                                end
                            end
                            default: begin
                                // A check of an empty table.
                                o_res.status    = mckw_pkg::ST_EMPTY;
                                o_res.entry_key = '0;
                            end
                        endcase
                    end
                end
            end

            // Check: skip free slots, read the next valid entry.
            S_CRD: begin
                if (r_valid[r_idx]) begin
                    o_ram.re = 1'b1;
                    n_state  = S_CEV;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            // Check: evaluate, write the entry back and report it.
            S_CEV: begin
                if (i_out_free) begin
                    o_push             = 1'b1;
                    o_res.status       = chk_status;
                    o_res.entry_key    = i_ram_rdata.key;
                    o_res.idle_seconds = idle;
                    o_res.last         = chk_stop || !later;
                    o_ram.we           = 1'b1;
                    o_ram.wdata        = row_upd;
                    if (chk_stop) begin
                        n_halted = 1'b1;
                        n_state  = S_IDLE;
                    end else if (!later) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_CRD;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_halted <= 1'b0;
            r_pv     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_halted <= n_halted;
            r_pv     <= n_pv;
        end
    end

    // Working registers of the current request.
    always_ff @(posedge i_clk) begin
        r_req   <= n_req;
        r_idx   <= n_idx;
        r_issue <= n_issue;
        r_pidx  <= n_pidx;
        r_found <= n_found;
        r_slot  <= n_slot;
        r_row   <= n_row;
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= mckw_pkg::TIMEOUT_RESET;
            r_term    <= mckw_pkg::TERM_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mckw_pkg::CFG_TIMEOUT: begin
                    r_timeout <= i_cfg_data[mckw_pkg::TMO_BITS-1:0];
                end
                mckw_pkg::CFG_TERMINATE: begin
                    r_term <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule
